// ===== rtl/kplpb_pkg.sv =====
`timescale 1ns / 1ps

package kplpb_pkg;

  // Number of keys that are tracked; key bits at or above this are ignored.
  localparam int NUM_KEYS = 7;

  // Fixed field widths.
  localparam int KEY_W   = 7;
  localparam int CNT_W   = 8;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 2;

  // Number of key lanes actually built.
  localparam int LANES = (NUM_KEYS < KEY_W) ? NUM_KEYS : KEY_W;

  // Mask of the key bits that are in use.
  localparam logic [KEY_W-1:0] KEYS_USED = KEY_W'((32'd1 << LANES) - 32'd1);

  // Reset values of the configuration registers and the pending count.
  localparam logic [CNT_W-1:0] LIMIT_RESET   = CNT_W'(200);
  localparam logic [KEY_W-1:0] MASK_RESET    = KEY_W'(127);
  localparam logic [CNT_W-1:0] PENDING_RESET = CNT_W'(1);
  localparam logic [CNT_W-1:0] PENDING_MAX   = CNT_W'(255);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS_LIMIT = 2'd0,
    REG_PRESS_BEEP_MASK  = 2'd1,
    REG_LONG_BEEP_MASK   = 2'd2
  } cfg_reg_t;

  // Input item.
  typedef struct packed {
    logic             beep_tick;
    logic             scan_valid;
    logic [KEY_W-1:0] key_bits;
    logic             beep_hold;
  } item_t;

  // Result item.
  typedef struct packed {
    logic             beeper_on;
    logic [KEY_W-1:0] press_edges;
    logic [KEY_W-1:0] long_edges;
    logic [KEY_W-1:0] keys_held;
    logic [CNT_W-1:0] pending_beeps;
  } result_t;

  // Configuration register contents shared by the lanes and the merge stage.
  typedef struct packed {
    logic [CNT_W-1:0] long_press_limit;
    logic [KEY_W-1:0] press_beep_mask;
    logic [KEY_W-1:0] long_beep_mask;
  } cfg_t;

endpackage

// ===== rtl/kplpb_lane.sv =====
`timescale 1ns / 1ps

module kplpb_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  key,
  input  logic [kplpb_pkg::CNT_W-1:0] limit,
  output logic                  long_press
);
  import kplpb_pkg::*;

  logic [CNT_W-1:0] hold_time;
  logic             at_limit;

  // A held key whose count has reached the limit is in long press.
  assign at_limit   = (hold_time >= limit);
  assign long_press = key & at_limit;

  // Count scans while the key is held; a release clears the count.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time <= '0;
    end else if (step) begin
      if (key) begin
        if (!at_limit) begin
          hold_time <= hold_time + CNT_W'(1);
        end
      end else begin
        hold_time <= '0;
      end
    end
  end

endmodule

// ===== rtl/kplpb_merge.sv =====
`timescale 1ns / 1ps

module kplpb_merge (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  kplpb_pkg::item_t        item,
  input  logic [kplpb_pkg::KEY_W-1:0] keys,
  input  logic [kplpb_pkg::KEY_W-1:0] long_vec,
  input  kplpb_pkg::cfg_t         cfg,
  output kplpb_pkg::result_t      result
);
  import kplpb_pkg::*;

  logic [KEY_W-1:0] prev_keys;
  logic [KEY_W-1:0] prev_long;
  logic [CNT_W-1:0] beep_pending;
  logic             beep_active;

  logic [KEY_W-1:0] prev_keys_next;
  logic [KEY_W-1:0] prev_long_next;
  logic [CNT_W-1:0] beep_pending_next;
  logic             beep_active_next;

  logic [CNT_W-1:0] pending_tick;
  logic             active_tick;
  logic [KEY_W-1:0] press;
  logic [KEY_W-1:0] lng_edge;
  logic             add_press;
  logic             add_long;
  logic [CNT_W:0]   pending_sum;

  // Beep tick is handled before the scan.
  always_comb begin
    pending_tick = beep_pending;
    active_tick  = beep_active;
    if (item.beep_tick) begin
      if (item.beep_hold) begin
        active_tick  = 1'b1;
        pending_tick = '0;
      end else if (beep_active) begin
        active_tick = 1'b0;
      end else if (beep_pending != '0) begin
        pending_tick = beep_pending - CNT_W'(1);
        active_tick  = 1'b1;
      end
    end
  end

  // Edge detection over all lanes and beep requests from the masks.
  always_comb begin
    press    = item.scan_valid ? (keys & ~prev_keys) : '0;
    lng_edge = item.scan_valid ? (long_vec & ~prev_long) : '0;
    add_press = |(press & cfg.press_beep_mask);
    add_long  = |(lng_edge & cfg.long_beep_mask);
    pending_sum = {1'b0, pending_tick} + {{CNT_W{1'b0}}, add_press}
                + {{CNT_W{1'b0}}, add_long};
  end

  // Next state; the pending count saturates at its maximum.
  always_comb begin
    prev_keys_next    = item.scan_valid ? keys : prev_keys;
    prev_long_next    = item.scan_valid ? long_vec : prev_long;
    beep_active_next  = active_tick;
    if (pending_sum > {1'b0, PENDING_MAX}) begin
      beep_pending_next = PENDING_MAX;
    end else begin
      beep_pending_next = pending_sum[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_keys    <= '0;
      prev_long    <= '0;
      beep_pending <= PENDING_RESET;
      beep_active  <= 1'b0;
    end else if (accept) begin
      prev_keys    <= prev_keys_next;
      prev_long    <= prev_long_next;
      beep_pending <= beep_pending_next;
      beep_active  <= beep_active_next;
    end
  end

  // Result of this item as it will be registered at the output.
  always_comb begin
    result.beeper_on     = beep_active_next;
    result.press_edges   = press;
    result.long_edges    = lng_edge;
    result.keys_held     = prev_keys_next;
    result.pending_beeps = beep_pending_next;
  end

endmodule

// ===== rtl/key_press_long_press_beeper.sv =====
`timescale 1ns / 1ps

// Key press and long-press detector with a paced beeper. The block takes one
// tick event per cycle and gives one result per event, in the cycle after the
// request is accepted, from an output register. The whole step (per-key hold
// counters in parallel lanes, edge merge and beeper update) is one level of
// logic, so a new request is accepted every cycle; ready drops only while the
// output register holds a result that has not been taken. There is no
// clearing pass after reset. Configuration writes are always accepted.
module key_press_long_press_beeper (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  kplpb_pkg::item_t              item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output kplpb_pkg::result_t            result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kplpb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kplpb_pkg::CFG_W-1:0]   cfg_data
);
  import kplpb_pkg::*;

  cfg_t             cfg;
  logic             accept;
  logic [KEY_W-1:0] keys;
  logic [KEY_W-1:0] long_vec;
  result_t          result_next;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;
  assign cfg_ready  = 1'b1;
  assign keys       = item.key_bits & KEYS_USED;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_limit <= LIMIT_RESET;
      cfg.press_beep_mask  <= MASK_RESET;
      cfg.long_beep_mask   <= MASK_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LONG_PRESS_LIMIT: cfg.long_press_limit <= cfg_data;
        REG_PRESS_BEEP_MASK:  cfg.press_beep_mask  <= cfg_data[KEY_W-1:0];
        REG_LONG_BEEP_MASK:   cfg.long_beep_mask   <= cfg_data[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  // One hold counter lane per key.
  genvar k;
  generate
    for (k = 0; k < KEY_W; k++) begin : g_lane
      if (k < LANES) begin : g_used
        kplpb_lane u_lane (
          .clk        (clk),
          .rst        (rst),
          .step       (accept && item.scan_valid),
          .key        (keys[k]),
          .limit      (cfg.long_press_limit),
          .long_press (long_vec[k])
        );
      end else begin : g_unused
        assign long_vec[k] = 1'b0;
      end
    end
  endgenerate

  // Merge the lanes and update the beeper.
  kplpb_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .keys     (keys),
    .long_vec (long_vec),
    .cfg      (cfg),
    .result   (result_next)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_ready) begin
      result_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  // A held beep on a tick with no scan leaves the beeper on and nothing pending.
  a_hold_forces_on: assert property (@(posedge clk) disable iff (rst)
    accept && item.beep_tick && item.beep_hold && !item.scan_valid |=>
      result_valid && result.beeper_on && (result.pending_beeps == '0))
    else $error("beep hold did not force the beeper on");

  // Press edges are always among the held keys.
  a_press_in_held: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.press_edges & ~result.keys_held) == '0))
    else $error("press edge on a key that is not held");

  // Long edges are always among the held keys.
  a_long_in_held: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.long_edges & ~result.keys_held) == '0))
    else $error("long edge on a key that is not held");

  // Without a scan no edges are reported.
  a_no_scan_no_edges: assert property (@(posedge clk) disable iff (rst)
    accept && !item.scan_valid |=>
      (result.press_edges == '0) && (result.long_edges == '0))
    else $error("edges reported without a scan");

endmodule

// ===== tb/key_press_long_press_beeper_test.sv =====
`timescale 1ns / 1ps

module key_press_long_press_beeper_test;
  import kplpb_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_STALL  = 80;

  // Kinds of row in the directed stimulus table.
  typedef enum logic {ROW_EVENT, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    cfg_reg_t         reg_idx;
    logic [CFG_W-1:0] reg_data;
    logic             typed;
    item_t            ev;
    result_t          res;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_ready;
  item_t            item = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  result_t          result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Shadow copy of the block's registers and key/beeper state.
  logic [CNT_W-1:0] cfg_limit = LIMIT_RESET;
  logic [KEY_W-1:0] cfg_press_mask = MASK_RESET;
  logic [KEY_W-1:0] cfg_long_mask = MASK_RESET;
  logic [KEY_W-1:0] keys_seen = '0;
  logic [KEY_W-1:0] long_seen = '0;
  logic [CNT_W-1:0] hold_count [LANES];
  logic [CNT_W-1:0] beeps_waiting = PENDING_RESET;
  logic             beeper_level = 1'b0;

  result_t          awaited_results [$];
  result_t          oldest_result;
  plan_row_t        plan [$];
  logic [KEY_W-1:0] key_pattern = '0;
  bit               stall_request = 1'b0;

  int mismatches = 0;
  int events_sent = 0;
  int results_checked = 0;
  int writes_done = 0;
  int long_results = 0;
  int full_results = 0;
  int quiet_cycles = 0;

  key_press_long_press_beeper dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Advance the shadow state by one tick event and return the result it gives.
  function automatic result_t beeper_step(item_t ev);
    result_t          r;
    logic [KEY_W-1:0] keys;
    logic [KEY_W-1:0] press;
    logic [KEY_W-1:0] longs;
    logic [KEY_W-1:0] long_edge;
    int               k;
    keys = ev.key_bits & KEYS_USED;
    press = '0;
    longs = '0;
    long_edge = '0;
    // The beep tick is handled before the scan.
    if (ev.beep_tick) begin
      if (ev.beep_hold) begin
        beeper_level = 1'b1;
        beeps_waiting = '0;
      end else if (beeper_level) begin
        beeper_level = 1'b0;
      end else if (beeps_waiting != '0) begin
        beeps_waiting = beeps_waiting - 1'b1;
        beeper_level = 1'b1;
      end
    end
    if (ev.scan_valid) begin
      press = keys & ~keys_seen;
      keys_seen = keys;
      if ((press & cfg_press_mask) != '0 && beeps_waiting != PENDING_MAX)
        beeps_waiting = beeps_waiting + 1'b1;
      // Held keys count up to the limit; a key already at the limit is long.
      for (k = 0; k < LANES; k++) begin
        if (keys[k]) begin
          if (hold_count[k] < cfg_limit)
            hold_count[k] = hold_count[k] + 1'b1;
          else
            longs[k] = 1'b1;
        end else begin
          hold_count[k] = '0;
        end
      end
      long_edge = longs & ~long_seen;
      long_seen = longs;
      if ((long_edge & cfg_long_mask) != '0 && beeps_waiting != PENDING_MAX)
        beeps_waiting = beeps_waiting + 1'b1;
    end
    r.beeper_on = beeper_level;
    r.press_edges = press;
    r.long_edges = long_edge;
    r.keys_held = keys_seen;
    r.pending_beeps = beeps_waiting;
    return r;
  endfunction

  // Table rows: an event checked by the predictor, an event with its result
  // written out, and a register write.
  function automatic plan_row_t ev_row(bit tick, bit scan, logic [KEY_W-1:0] keys, bit hold);
    plan_row_t row;
    row = '0;
    row.kind = ROW_EVENT;
    row.ev = '{beep_tick: tick, scan_valid: scan, key_bits: keys, beep_hold: hold};
    return row;
  endfunction

  function automatic plan_row_t ev_known(bit tick, bit scan, logic [KEY_W-1:0] keys, bit hold,
                                         bit on, logic [KEY_W-1:0] pe, logic [KEY_W-1:0] le,
                                         logic [KEY_W-1:0] kh, logic [CNT_W-1:0] pb);
    plan_row_t row;
    row = ev_row(tick, scan, keys, hold);
    row.typed = 1'b1;
    row.res = '{beeper_on: on, press_edges: pe, long_edges: le, keys_held: kh,
                pending_beeps: pb};
    return row;
  endfunction

  function automatic plan_row_t wr_row(cfg_reg_t idx, logic [CFG_W-1:0] data);
    plan_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.reg_idx = idx;
    row.reg_data = data;
    return row;
  endfunction

  // Random tick event; key scans follow a slowly changing key pattern.
  function automatic item_t random_event(int tick_pct, int scan_pct, int change_pm,
                                         int hold_pct);
    item_t ev;
    if ($urandom_range(0, 999) < change_pm) begin
      if ($urandom_range(0, 1) == 1)
        key_pattern = KEY_W'($urandom_range(0, 127));
      else
        key_pattern = key_pattern ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
    end
    ev.beep_tick = ($urandom_range(0, 99) < tick_pct);
    ev.scan_valid = ($urandom_range(0, 99) < scan_pct);
    ev.key_bits = ev.scan_valid ? key_pattern : KEY_W'($urandom_range(0, 127));
    ev.beep_hold = ($urandom_range(0, 99) < hold_pct);
    return ev;
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Offer one request and record its expected result once it is taken.
  task automatic offer_event(item_t ev, bit typed, result_t typed_res);
    result_t predicted;
    @(negedge clk);
    item <= ev;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!(item_valid && item_ready))
      @(posedge clk);
    predicted = beeper_step(ev);
    awaited_results.push_back(typed ? typed_res : predicted);
    events_sent++;
  endtask

  task automatic write_register(cfg_reg_t idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready))
      @(posedge clk);
    case (idx)
      REG_LONG_PRESS_LIMIT: cfg_limit = data;
      REG_PRESS_BEEP_MASK:  cfg_press_mask = data[KEY_W-1:0];
      REG_LONG_BEEP_MASK:   cfg_long_mask = data[KEY_W-1:0];
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (awaited_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic configure(logic [CNT_W-1:0] limit, logic [KEY_W-1:0] press_mask,
                           logic [KEY_W-1:0] long_mask);
    drain_results();
    write_register(REG_LONG_PRESS_LIMIT, limit);
    write_register(REG_PRESS_BEEP_MASK, {1'b0, press_mask});
    write_register(REG_LONG_BEEP_MASK, {1'b0, long_mask});
  endtask

  // Requests go out in bursts with random gaps; one phase may also ask the
  // receiver for a long stall and pause the sender until all results are in.
  task automatic run_phase(int count, int tick_pct, int scan_pct, int change_pm,
                           int hold_pct, int stall_at, int pause_at);
    int done;
    int burst;
    int gap;
    int j;
    done = 0;
    while (done < count) begin
      burst = $urandom_range(1, 24);
      for (j = 0; j < burst && done < count; j++) begin
        offer_event(random_event(tick_pct, scan_pct, change_pm, hold_pct), 1'b0, '0);
        done++;
        if (done == stall_at)
          stall_request = 1'b1;
        if (done == pause_at)
          drain_results();
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        item_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Receiver: changes its stall pattern after a random stretch, and holds off
  // for a long stretch when asked.
  initial begin : sink
    int mode;
    int mode_left;
    int stall_left;
    mode = 0;
    mode_left = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_left = LONG_STALL;
        stall_request = 1'b0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        case (mode)
          0: result_ready <= 1'b1;
          1: result_ready <= ($urandom_range(0, 1) == 1);
          default: result_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compare each result taken with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (awaited_results.size() == 0) begin
        note_mismatch("result with no request outstanding");
      end else begin
        oldest_result = awaited_results.pop_front();
        results_checked++;
        if (oldest_result.long_edges != '0)
          long_results++;
        if (oldest_result.pending_beeps == PENDING_MAX)
          full_results++;
        if (result.beeper_on !== oldest_result.beeper_on)
          note_mismatch($sformatf("beeper_on got %b want %b",
                                  result.beeper_on, oldest_result.beeper_on));
        if (result.press_edges !== oldest_result.press_edges)
          note_mismatch($sformatf("press_edges got %h want %h",
                                  result.press_edges, oldest_result.press_edges));
        if (result.long_edges !== oldest_result.long_edges)
          note_mismatch($sformatf("long_edges got %h want %h",
                                  result.long_edges, oldest_result.long_edges));
        if (result.keys_held !== oldest_result.keys_held)
          note_mismatch($sformatf("keys_held got %h want %h",
                                  result.keys_held, oldest_result.keys_held));
        if (result.pending_beeps !== oldest_result.pending_beeps)
          note_mismatch($sformatf("pending_beeps got %0d want %0d",
                                  result.pending_beeps, oldest_result.pending_beeps));
      end
    end
  end

  // Watchdog on cycles in which no request moves on any channel.
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timed out after %0d cycles with no progress.", QUIET_LIMIT);
      $display("key_press_long_press_beeper_test NOT OK");
      $finish;
    end
  end

  initial begin : main
    int n;
    for (n = 0; n < LANES; n++)
      hold_count[n] = '0;

    // Directed table: power-up beep, beeper pacing, beep hold, scans at the
    // key extremes, limit zero, masks cleared and the widest limit.
    plan.push_back(ev_known(0, 0, 7'h00, 0,  0, 7'h00, 7'h00, 7'h00, 8'd1));
    plan.push_back(ev_known(1, 0, 7'h00, 0,  1, 7'h00, 7'h00, 7'h00, 8'd0));
    plan.push_back(ev_known(1, 0, 7'h00, 0,  0, 7'h00, 7'h00, 7'h00, 8'd0));
    plan.push_back(ev_known(1, 0, 7'h00, 0,  0, 7'h00, 7'h00, 7'h00, 8'd0));
    plan.push_back(ev_known(0, 1, 7'h7f, 0,  0, 7'h7f, 7'h00, 7'h7f, 8'd1));
    plan.push_back(ev_known(1, 1, 7'h7f, 0,  1, 7'h00, 7'h00, 7'h7f, 8'd0));
    plan.push_back(ev_known(0, 0, 7'h55, 1,  1, 7'h00, 7'h00, 7'h7f, 8'd0));
    plan.push_back(ev_known(1, 0, 7'h00, 1,  1, 7'h00, 7'h00, 7'h7f, 8'd0));
    plan.push_back(ev_known(0, 1, 7'h00, 0,  1, 7'h00, 7'h00, 7'h00, 8'd0));
    plan.push_back(wr_row(REG_LONG_PRESS_LIMIT, 8'd0));
    plan.push_back(ev_known(0, 1, 7'h01, 0,  1, 7'h01, 7'h01, 7'h01, 8'd2));
    plan.push_back(ev_row(0, 1, 7'h01, 0));
    plan.push_back(ev_row(1, 1, 7'h2a, 0));
    plan.push_back(wr_row(REG_PRESS_BEEP_MASK, 8'd0));
    plan.push_back(wr_row(REG_LONG_BEEP_MASK, 8'd0));
    plan.push_back(ev_row(0, 1, 7'h7f, 0));
    plan.push_back(ev_row(1, 1, 7'h00, 1));
    plan.push_back(wr_row(REG_LONG_PRESS_LIMIT, 8'd255));
    plan.push_back(wr_row(REG_PRESS_BEEP_MASK, 8'd127));
    plan.push_back(wr_row(REG_LONG_BEEP_MASK, 8'd127));
    plan.push_back(ev_row(0, 1, 7'h40, 0));
    plan.push_back(ev_row(1, 1, 7'h40, 1));
    plan.push_back(ev_row(1, 0, 7'h3f, 0));
    plan.push_back(ev_row(1, 1, 7'h3f, 0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain_results();
        write_register(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        offer_event(plan[i].ev, plan[i].typed, plan[i].res);
      end
    end

    // General mix with a short limit.
    configure(8'd3, KEY_W'($urandom_range(0, 127)), KEY_W'($urandom_range(0, 127)));
    run_phase(400, 20, 60, 300, 10, -1, -1);
    // No beep ticks and frequent presses: the pending count runs into its ceiling.
    configure(8'd0, 7'h7f, 7'h7f);
    run_phase(300, 0, 90, 700, 0, -1, -1);
    // Mostly ticks with beep hold, which empties the pending count.
    run_phase(60, 90, 10, 200, 40, -1, -1);
    // Widest limit with keys held steady long enough to reach long press.
    configure(8'd255, KEY_W'($urandom_range(0, 127)), KEY_W'($urandom_range(0, 127)));
    run_phase(560, 25, 80, 4, 5, -1, -1);
    // Small random limit, with a long receiver stall and a full sender pause.
    configure(CNT_W'($urandom_range(1, 10)), KEY_W'($urandom_range(0, 127)),
              KEY_W'($urandom_range(0, 127)));
    run_phase(400, 30, 60, 250, 15, 100, 250);
    // Reset limit with one mask cleared and the other full.
    configure(LIMIT_RESET, 7'h00, 7'h7f);
    run_phase(230, 40, 70, 200, 10, -1, -1);

    drain_results();
    repeat (5) @(posedge clk);

    $display("Run covered %0d tick events, %0d checked results, %0d register writes.",
             events_sent, results_checked, writes_done);
    $display("Long-press edges appeared in %0d results; pending count sat at 255 in %0d.",
             long_results, full_results);
    if (mismatches == 0)
      $display("key_press_long_press_beeper_test OK");
    else
      $display("key_press_long_press_beeper_test NOT OK");
    $finish;
  end

endmodule
